>>> design/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

  // Request kinds
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned DATE_W    = 27;
  localparam int unsigned PAYLOAD_W = 64;

  typedef struct packed {
    logic                 op;
    logic [15:0]          key;
    logic [YEAR_W-1:0]    reg_year;
    logic [DATE_W-1:0]    inspect_date;
    logic [PAYLOAD_W-1:0] payload;
  } in_req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [7:0]           position;
    logic [YEAR_W-1:0]    out_year;
    logic [DATE_W-1:0]    out_date;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [8:0]           entry_count;
  } out_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_HCMP,
    S_DEC,
    S_SHRD,
    S_SHWR,
    S_INS,
    S_OUT
  } state_e;

endpackage

>>> design/skt_ram.sv
`timescale 1ns / 1ps

module skt_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 119,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sorted_key_table_unit.sv
`timescale 1ns / 1ps
// Sorted key table: records kept in ascending key order in one RAM with separate read and write ports.
// A lookup runs a binary search over the n stored entries, each step issuing one RAM read and
// one compare, then fetches the slot where the window closed, if filled, to check for a match.
// An insert then moves every larger entry up one slot, top slot first, before writing the record.
// One request at a time: the next is taken once the result is registered.
// Reset clears control state and the fill count; table contents need no clearing pass.

module sorted_key_table_unit #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  skt_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output skt_pkg::out_rsp_t out_rsp_o
);

  // Table geometry
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = KEY_BITS + skt_pkg::YEAR_W + skt_pkg::DATE_W
                               + skt_pkg::PAYLOAD_W;

  // Record layout inside a RAM word: {key, year, date, payload}
  localparam int unsigned PAY_LO  = 0;
  localparam int unsigned DATE_LO = PAY_LO + skt_pkg::PAYLOAD_W;
  localparam int unsigned YEAR_LO = DATE_LO + skt_pkg::DATE_W;
  localparam int unsigned KEY_LO  = YEAR_LO + skt_pkg::YEAR_W;

  skt_pkg::state_e   state_q, state_d;
  skt_pkg::in_req_t  req_q, req_d;
  skt_pkg::out_rsp_t out_rsp_q, out_rsp_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hi_q, hi_d;
  logic [CW-1:0]     shift_q, shift_d;
  logic [2:0]        status_q, status_d;
  logic              hit_q, hit_d;

  logic [CW-1:0]     mid;
  logic [31:0]       key_ext;
  logic [KEY_BITS-1:0] req_key;
  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]       lo_ext;
  logic [31:0]       count_ext;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [RW-1:0]     ram_rdata;

  skt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (RW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Only the low KEY_BITS of the request key take part in ordering
  assign key_ext   = 32'(req_q.key);
  assign req_key   = key_ext[KEY_BITS-1:0];
  assign rd_key    = ram_rdata[KEY_LO +: KEY_BITS];
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_ext    = 32'(lo_q);
  assign count_ext = 32'(count_q);

  assign in_stall_o  = (state_q != skt_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    out_rsp_q <= out_rsp_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    shift_q   <= shift_d;
    status_q  <= status_d;
    hit_q     <= hit_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    shift_d     = shift_q;
    status_d    = status_q;
    hit_d       = hit_q;

    ram_we    = 1'b0;
    ram_waddr = AW'(shift_q);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = AW'(mid);

    // Drop the held result once downstream takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      skt_pkg::S_IDLE: begin
        // Take a new request and open the search window over the filled slots
        if (in_valid_i) begin
          req_d   = in_req_i;
          lo_d    = '0;
          hi_d    = count_q;
          state_d = skt_pkg::S_SRCH;
        end
      end

      skt_pkg::S_SRCH: begin
        if (lo_q < hi_q) begin
          ram_re  = 1'b1;
          state_d = skt_pkg::S_SCMP;
        end else if (lo_q < count_q) begin
          // Window closed on a filled slot: fetch it to check for a match
          ram_re    = 1'b1;
          ram_raddr = AW'(lo_q);
          state_d   = skt_pkg::S_HCMP;
        end else begin
          hit_d   = 1'b0;
          state_d = skt_pkg::S_DEC;
        end
      end

      skt_pkg::S_SCMP: begin
        // Narrow the window by comparing the read key with the request key
        if (rd_key < req_key) begin
          lo_d = mid + CW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = skt_pkg::S_SRCH;
      end

      skt_pkg::S_HCMP: begin
        // RAM read data stays held for the found-record fields
        hit_d   = (rd_key == req_key);
        state_d = skt_pkg::S_DEC;
      end

      skt_pkg::S_DEC: begin
        if (req_q.op == skt_pkg::OP_LOOKUP) begin
          status_d = hit_q ? skt_pkg::ST_FOUND : skt_pkg::ST_MISS;
          state_d  = skt_pkg::S_OUT;
        end else if (hit_q) begin
          status_d = skt_pkg::ST_DUP;
          state_d  = skt_pkg::S_OUT;
        end else if (count_q >= CW'(CAPACITY)) begin
          status_d = skt_pkg::ST_FULL;
          state_d  = skt_pkg::S_OUT;
        end else begin
          shift_d  = count_q;
          status_d = skt_pkg::ST_INSERTED;
          state_d  = skt_pkg::S_SHRD;
        end
      end

      skt_pkg::S_SHRD: begin
        // Move larger entries up, top slot first
        if (shift_q > lo_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(shift_q - CW'(1));
          state_d   = skt_pkg::S_SHWR;
        end else begin
          state_d = skt_pkg::S_INS;
        end
      end

      skt_pkg::S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(shift_q);
        ram_wdata = ram_rdata;
        shift_d   = shift_q - CW'(1);
        state_d   = skt_pkg::S_SHRD;
      end

      skt_pkg::S_INS: begin
        // Fill the gap with the new record
        ram_we    = 1'b1;
        ram_waddr = AW'(lo_q);
        ram_wdata = {req_key, req_q.reg_year, req_q.inspect_date, req_q.payload};
        count_d   = count_q + CW'(1);
        state_d   = skt_pkg::S_OUT;
      end

      skt_pkg::S_OUT: begin
        // Hold here until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_rsp_d             = '0;
          out_rsp_d.status      = status_q;
          out_rsp_d.entry_count = count_ext[8:0];
          if (status_q == skt_pkg::ST_INSERTED || status_q == skt_pkg::ST_FOUND) begin
            out_rsp_d.position = lo_ext[7:0];
          end
          if (status_q == skt_pkg::ST_FOUND) begin
            out_rsp_d.out_year    = ram_rdata[YEAR_LO +: skt_pkg::YEAR_W];
            out_rsp_d.out_date    = ram_rdata[DATE_LO +: skt_pkg::DATE_W];
            out_rsp_d.out_payload = ram_rdata[PAY_LO +: skt_pkg::PAYLOAD_W];
          end
          state_d = skt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Fill count never passes the table capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Search window stays ordered and inside the filled slots
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skt_pkg::S_SRCH) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search window out of order");

  // Entry moves only happen above the insert slot and within the free slot
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skt_pkg::S_SHWR) |-> (shift_q > lo_q && shift_q <= count_q))
    else $error("entry move outside the shift range");

  // An insert into the table grows it by exactly one entry
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skt_pkg::S_INS) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the fill count");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned RANDOM_REQS = 632;
  // Longest request: full binary search plus moving every entry up one slot.
  localparam int unsigned DRAIN_CYCLES = 600;

  // Shadow of the table contents.
  // Predicts the response of every accepted request and checks the responses
  // in the order they leave the block.
  class table_tracker;
    logic [15:0]                   stored_keys     [TABLE_DEPTH];
    logic [skt_pkg::YEAR_W-1:0]    stored_years    [TABLE_DEPTH];
    logic [skt_pkg::DATE_W-1:0]    stored_dates    [TABLE_DEPTH];
    logic [skt_pkg::PAYLOAD_W-1:0] stored_payloads [TABLE_DEPTH];
    int unsigned                   stored_count;
    skt_pkg::out_rsp_t             expected_rsps [$];
    int unsigned                   mismatches;

    function new();
      stored_count = 0;
      mismatches   = 0;
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction

    // First slot whose key is not below k, within 0..stored_count.
    function int unsigned first_slot_not_below(logic [15:0] k);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = stored_count;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (stored_keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // Apply one accepted request to the shadow table and queue its response.
    function void note_request(skt_pkg::in_req_t r);
      skt_pkg::out_rsp_t rsp;
      int unsigned       slot;
      int unsigned       i;
      bit                hit;
      rsp  = '0;
      slot = first_slot_not_below(r.key);
      hit  = (slot < stored_count) && (stored_keys[slot] == r.key);
      if (r.op == skt_pkg::OP_INSERT) begin
        if (hit) begin
          rsp.status = skt_pkg::ST_DUP;
        end else if (stored_count >= TABLE_DEPTH) begin
          rsp.status = skt_pkg::ST_FULL;
        end else begin
          i = stored_count;
          while (i > slot) begin
            stored_keys[i]     = stored_keys[i-1];
            stored_years[i]    = stored_years[i-1];
            stored_dates[i]    = stored_dates[i-1];
            stored_payloads[i] = stored_payloads[i-1];
            i--;
          end
          stored_keys[slot]     = r.key;
          stored_years[slot]    = r.reg_year;
          stored_dates[slot]    = r.inspect_date;
          stored_payloads[slot] = r.payload;
          stored_count++;
          rsp.status   = skt_pkg::ST_INSERTED;
          rsp.position = 8'(slot);
        end
      end else if (hit) begin
        rsp.status      = skt_pkg::ST_FOUND;
        rsp.position    = 8'(slot);
        rsp.out_year    = stored_years[slot];
        rsp.out_date    = stored_dates[slot];
        rsp.out_payload = stored_payloads[slot];
      end else begin
        rsp.status = skt_pkg::ST_MISS;
      end
      rsp.entry_count = 9'(stored_count);
      expected_rsps.push_back(rsp);
    endfunction

    function void flag(string field, logic [63:0] want_v, logic [63:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want_v, got_v);
    endfunction

    function void check_response(skt_pkg::out_rsp_t got);
      skt_pkg::out_rsp_t want;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("response with nothing outstanding: %h", got);
        return;
      end
      want = expected_rsps.pop_front();
      if (got.status !== want.status)
        flag("status", 64'(want.status), 64'(got.status));
      if (got.position !== want.position)
        flag("position", 64'(want.position), 64'(got.position));
      if (got.out_year !== want.out_year)
        flag("out_year", 64'(want.out_year), 64'(got.out_year));
      if (got.out_date !== want.out_date)
        flag("out_date", 64'(want.out_date), 64'(got.out_date));
      if (got.out_payload !== want.out_payload)
        flag("out_payload", want.out_payload, got.out_payload);
      if (got.entry_count !== want.entry_count)
        flag("entry_count", 64'(want.entry_count), 64'(got.entry_count));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              req_valid;
  logic              req_stall;
  skt_pkg::in_req_t  req;
  logic              rsp_valid;
  logic              rsp_stall;
  skt_pkg::out_rsp_t rsp;

  table_tracker tracker;
  int unsigned  sent;
  bit           steady_send;

  sorted_key_table_unit #(
    .CAPACITY(TABLE_DEPTH),
    .KEY_BITS(16)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_req_i   (req),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_rsp_o  (rsp)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic skt_pkg::in_req_t make_request(
    logic                          op,
    logic [15:0]                   key,
    logic [skt_pkg::YEAR_W-1:0]    year,
    logic [skt_pkg::DATE_W-1:0]    date,
    logic [skt_pkg::PAYLOAD_W-1:0] payload
  );
    skt_pkg::in_req_t r;
    r.op           = op;
    r.key          = key;
    r.reg_year     = year;
    r.inspect_date = date;
    r.payload      = payload;
    return r;
  endfunction

  // Mostly well-formed traffic: fill the table with fresh keys, mixed with
  // duplicates and lookups, about half of them of keys known to be stored. Once full, keep
  // hammering it with refused inserts and lookups.
  function automatic skt_pkg::in_req_t random_request();
    skt_pkg::in_req_t r;
    int unsigned      roll;
    bit               reuse;
    r.key          = 16'($urandom);
    r.reg_year     = 12'($urandom);
    r.inspect_date = 27'($urandom);
    r.payload      = {$urandom, $urandom};
    roll           = $urandom_range(0, 99);
    if (tracker.stored_count < TABLE_DEPTH) begin
      r.op  = (roll < 70) ? skt_pkg::OP_INSERT : skt_pkg::OP_LOOKUP;
      reuse = (roll >= 60 && roll < 70) || (roll >= 70 && $urandom_range(0, 1) == 1);
    end else begin
      r.op  = (roll < 40) ? skt_pkg::OP_INSERT : skt_pkg::OP_LOOKUP;
      reuse = ($urandom_range(0, 1) == 1);
    end
    if (reuse && tracker.stored_count > 0)
      r.key = tracker.stored_keys[$urandom_range(0, tracker.stored_count - 1)];
    return r;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  // Every fortieth request, decide whether the next stretch runs back to back.
  task automatic offer(skt_pkg::in_req_t r);
    int unsigned gap;
    if (sent % 40 == 0) steady_send = ($urandom_range(0, 3) == 0);
    gap = steady_send ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    tracker.note_request(r);
    sent++;
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    skt_pkg::in_req_t r;
    tracker     = new();
    sent        = 0;
    steady_send = 1'b0;
    rst_n       = 1'b0;
    req_valid   = 1'b0;
    req         = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lookup on an empty table must miss.
    offer(make_request(skt_pkg::OP_LOOKUP, 16'h1234, 12'd7, 27'd1, 64'd1));
    offer(make_request(skt_pkg::OP_INSERT, 16'h8000, 12'd2024, 27'd20230115,
                       64'h0123_4567_89ab_cdef));
    // Smallest key goes in front, shifting the existing entry up.
    offer(make_request(skt_pkg::OP_INSERT, 16'h0000, '0, '0, '0));
    // Largest key with every record field at its maximum, appended at the end.
    offer(make_request(skt_pkg::OP_INSERT, 16'hffff, '1, '1, '1));
    offer(make_request(skt_pkg::OP_INSERT, 16'h4000, 12'd1999, 27'd19990101,
                       64'hdead_beef_0000_0001));
    // Duplicate insert: dropped, table unchanged.
    offer(make_request(skt_pkg::OP_INSERT, 16'h8000, 12'd1, 27'd2, 64'd3));
    offer(make_request(skt_pkg::OP_LOOKUP, 16'h0000, '1, '1, '1));
    offer(make_request(skt_pkg::OP_LOOKUP, 16'hffff, '0, '0, '0));
    offer(make_request(skt_pkg::OP_LOOKUP, 16'h8000, '0, '0, '0));
    offer(make_request(skt_pkg::OP_LOOKUP, 16'h4000, '0, '0, '0));
    // Misses between and beside stored keys.
    offer(make_request(skt_pkg::OP_LOOKUP, 16'h7fff, '0, '0, '0));
    offer(make_request(skt_pkg::OP_LOOKUP, 16'h0001, '0, '0, '0));
    offer(make_request(skt_pkg::OP_INSERT, 16'h0001, 12'haaa, 27'h5555555,
                       64'h5555_5555_5555_5555));
    offer(make_request(skt_pkg::OP_LOOKUP, 16'h0001, '0, '0, '0));
    offer(make_request(skt_pkg::OP_INSERT, 16'hffff, 12'h555, 27'h2aaaaaa,
                       64'haaaa_aaaa_aaaa_aaaa));
    offer(make_request(skt_pkg::OP_INSERT, 16'h0000, 12'h123, 27'h1234567, 64'h1));
    offer(make_request(skt_pkg::OP_INSERT, 16'hfffe, 12'h800, 27'h4000000,
                       64'h8000_0000_0000_0000));
    offer(make_request(skt_pkg::OP_LOOKUP, 16'hfffe, '0, '0, '0));

    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      // Once, let the block drain completely before carrying on.
      if (n == 400) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
      end
      r = random_request();
      offer(r);
    end
    req_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    // Leave room for any stray response.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("sorted_key_table_unit regression: pass");
    end else begin
      $display("sorted_key_table_unit regression: fail");
    end
    $finish;
  end

  // Response side: stall at random, once for a long stretch so that the block
  // backs up and stalls its request side.
  initial begin : responses
    int unsigned hold;
    int unsigned taken;
    bit          steady;
    rsp_stall = 1'b0;
    taken     = 0;
    steady    = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      hold = steady ? 0 : $urandom_range(0, 15);
      if (taken == 150) hold = 400;
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      tracker.check_response(rsp);
      taken++;
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #15_000_000;
    $display("sorted_key_table_unit regression: fail");
    $finish;
  end

endmodule

>>> sim.f
design/skt_pkg.sv
design/skt_ram.sv
design/sorted_key_table_unit.sv
tb/tb_top.sv
